>>> rtl/sm83_alu_flags_core_assert.svh
// assertion macros for the sm83 alu core
// each macro assumes a clock named clk and an active-low reset named rst_n
`ifndef SM83_ALU_FLAGS_CORE_ASSERT_SVH
`define SM83_ALU_FLAGS_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SM83AF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sm83 alu check failed");
`define SM83AF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sm83 alu check failed");
`else
`define SM83AF_ASSERT_SAME(label, ante, cons)
`define SM83AF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/sm83af_pkg.sv
package sm83af_pkg;

    // operation codes
    typedef enum logic [5:0] {
        OP_ADD   = 6'd0,
        OP_ADC   = 6'd1,
        OP_SUB   = 6'd2,
        OP_SBC   = 6'd3,
        OP_AND   = 6'd4,
        OP_XOR   = 6'd5,
        OP_OR    = 6'd6,
        OP_CP    = 6'd7,
        OP_RLC   = 6'd8,
        OP_RRC   = 6'd9,
        OP_RL    = 6'd10,
        OP_RR    = 6'd11,
        OP_SLA   = 6'd12,
        OP_SRA   = 6'd13,
        OP_SWAP  = 6'd14,
        OP_SRL   = 6'd15,
        OP_BIT   = 6'd16,
        OP_RES   = 6'd17,
        OP_SET   = 6'd18,
        OP_INC8  = 6'd19,
        OP_DEC8  = 6'd20,
        OP_RLCA  = 6'd21,
        OP_RRCA  = 6'd22,
        OP_RLA   = 6'd23,
        OP_RRA   = 6'd24,
        OP_DAA   = 6'd25,
        OP_CPL   = 6'd26,
        OP_SCF   = 6'd27,
        OP_CCF   = 6'd28,
        OP_ADD16 = 6'd29,
        OP_ADDSP = 6'd30,
        OP_INC16 = 6'd31,
        OP_DEC16 = 6'd32
    } op_t;

    // flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // one input item
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] left;
        logic [15:0] right;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } alu_in_t;

    // one result item
    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
    } alu_out_t;

    // zero flag of an 8-bit value
    function automatic logic zero8(input logic [7:0] v);
        return (v == 8'h00);
    endfunction

endpackage

>>> rtl/sm83af_alu.sv
module sm83af_alu
(
    input  sm83af_pkg::alu_in_t  item,
    output sm83af_pkg::alu_out_t res
);

    sm83af_pkg::op_t op;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic [3:0]  f;
    logic        ct;
    logic [8:0]  add9;
    logic [4:0]  addh5;
    logic [8:0]  sub9;
    logic [4:0]  subh5;
    logic [16:0] add17;
    logic [12:0] addh13;
    logic [15:0] sp_sum;
    logic [4:0]  sp_h5;
    logic [8:0]  sp_c9;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  mask;
    logic        daa_hi;
    logic        daa_lo;
    logic [7:0]  daa_val;
    logic        daa_c;

    // operand fields
    assign op  = sm83af_pkg::op_t'(item.kind);
    assign a   = item.left[7:0];
    assign b   = item.right[7:0];
    assign f   = item.flags_in;
    assign cin = item.flags_in[sm83af_pkg::FLAG_C];

    // shared adders
    assign ct     = ((op == sm83af_pkg::OP_ADC) || (op == sm83af_pkg::OP_SBC)) ? cin : 1'b0;
    assign add9   = {1'b0, a} + {1'b0, b} + {8'd0, ct};
    assign addh5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ct};
    assign sub9   = {1'b0, a} - {1'b0, b} - {8'd0, ct};
    assign subh5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ct};
    assign add17  = {1'b0, item.left} + {1'b0, item.right};
    assign addh13 = {1'b0, item.left[11:0]} + {1'b0, item.right[11:0]};
    assign sp_sum = item.left + {{8{b[7]}}, b};
    assign sp_h5  = {1'b0, item.left[3:0]} + {1'b0, b[3:0]};
    assign sp_c9  = {1'b0, item.left[7:0]} + {1'b0, b};
    assign inc8   = a + 8'd1;
    assign dec8   = a - 8'd1;
    assign mask   = 8'd1 << item.bit_index;

    // decimal adjust
    always_comb
    begin
        daa_hi = cin || (a > 8'h99);
        daa_lo = f[sm83af_pkg::FLAG_H] || (a[3:0] > 4'h9);
        if (f[sm83af_pkg::FLAG_N])
        begin
            daa_val = a - (f[sm83af_pkg::FLAG_H] ? 8'h06 : 8'h00) - (cin ? 8'h60 : 8'h00);
            daa_c   = cin;
        end
        else
        begin
            daa_val = a + (daa_hi ? 8'h60 : 8'h00) + (daa_lo ? 8'h06 : 8'h00);
            daa_c   = daa_hi;
        end
    end

    // operation select
    always_comb
    begin
        res.result    = 16'h0000;
        res.flags_out = f;
        unique case (op) inside
            sm83af_pkg::OP_ADD, sm83af_pkg::OP_ADC:
            begin
                res.result    = {8'h00, add9[7:0]};
                res.flags_out = {sm83af_pkg::zero8(add9[7:0]), 1'b0, addh5[4], add9[8]};
            end
            sm83af_pkg::OP_SUB, sm83af_pkg::OP_SBC, sm83af_pkg::OP_CP:
            begin
                res.result    = {8'h00, (op == sm83af_pkg::OP_CP) ? a : sub9[7:0]};
                res.flags_out = {sm83af_pkg::zero8(sub9[7:0]), 1'b1, subh5[4], sub9[8]};
            end
            sm83af_pkg::OP_AND:
            begin
                res.result    = {8'h00, a & b};
                res.flags_out = {sm83af_pkg::zero8(a & b), 1'b0, 1'b1, 1'b0};
            end
            sm83af_pkg::OP_XOR:
            begin
                res.result    = {8'h00, a ^ b};
                res.flags_out = {sm83af_pkg::zero8(a ^ b), 3'b000};
            end
            sm83af_pkg::OP_OR:
            begin
                res.result    = {8'h00, a | b};
                res.flags_out = {sm83af_pkg::zero8(a | b), 3'b000};
            end
            sm83af_pkg::OP_RLC:
            begin
                res.result    = {8'h00, a[6:0], a[7]};
                res.flags_out = {sm83af_pkg::zero8(a), 2'b00, a[7]};
            end
            sm83af_pkg::OP_RLCA:
            begin
                res.result    = {8'h00, a[6:0], a[7]};
                res.flags_out = {3'b000, a[7]};
            end
            sm83af_pkg::OP_RRC:
            begin
                res.result    = {8'h00, a[0], a[7:1]};
                res.flags_out = {sm83af_pkg::zero8(a), 2'b00, a[0]};
            end
            sm83af_pkg::OP_RRCA:
            begin
                res.result    = {8'h00, a[0], a[7:1]};
                res.flags_out = {3'b000, a[0]};
            end
            sm83af_pkg::OP_RL:
            begin
                res.result    = {8'h00, a[6:0], cin};
                res.flags_out = {sm83af_pkg::zero8({a[6:0], cin}), 2'b00, a[7]};
            end
            sm83af_pkg::OP_RLA:
            begin
                res.result    = {8'h00, a[6:0], cin};
                res.flags_out = {3'b000, a[7]};
            end
            sm83af_pkg::OP_RR:
            begin
                res.result    = {8'h00, cin, a[7:1]};
                res.flags_out = {sm83af_pkg::zero8({cin, a[7:1]}), 2'b00, a[0]};
            end
            sm83af_pkg::OP_RRA:
            begin
                res.result    = {8'h00, cin, a[7:1]};
                res.flags_out = {3'b000, a[0]};
            end
            sm83af_pkg::OP_SLA:
            begin
                res.result    = {8'h00, a[6:0], 1'b0};
                res.flags_out = {sm83af_pkg::zero8({a[6:0], 1'b0}), 2'b00, a[7]};
            end
            sm83af_pkg::OP_SRA:
            begin
                res.result    = {8'h00, a[7], a[7:1]};
                res.flags_out = {sm83af_pkg::zero8({a[7], a[7:1]}), 2'b00, a[0]};
            end
            sm83af_pkg::OP_SWAP:
            begin
                res.result    = {8'h00, a[3:0], a[7:4]};
                res.flags_out = {sm83af_pkg::zero8(a), 3'b000};
            end
            sm83af_pkg::OP_SRL:
            begin
                res.result    = {8'h00, 1'b0, a[7:1]};
                res.flags_out = {sm83af_pkg::zero8({1'b0, a[7:1]}), 2'b00, a[0]};
            end
            sm83af_pkg::OP_BIT:
            begin
                res.result    = {8'h00, a};
                res.flags_out = {sm83af_pkg::zero8(a & mask), 1'b0, 1'b1, cin};
            end
            sm83af_pkg::OP_RES:
            begin
                res.result = {8'h00, a & ~mask};
            end
            sm83af_pkg::OP_SET:
            begin
                res.result = {8'h00, a | mask};
            end
            sm83af_pkg::OP_INC8:
            begin
                res.result    = {8'h00, inc8};
                res.flags_out = {sm83af_pkg::zero8(inc8), 1'b0, (inc8[3:0] == 4'h0), cin};
            end
            sm83af_pkg::OP_DEC8:
            begin
                res.result    = {8'h00, dec8};
                res.flags_out = {sm83af_pkg::zero8(dec8), 1'b1, (dec8[3:0] == 4'hf), cin};
            end
            sm83af_pkg::OP_DAA:
            begin
                res.result    = {8'h00, daa_val};
                res.flags_out = {sm83af_pkg::zero8(daa_val), f[sm83af_pkg::FLAG_N], 1'b0, daa_c};
            end
            sm83af_pkg::OP_CPL:
            begin
                res.result    = {8'h00, ~a};
                res.flags_out = {f[sm83af_pkg::FLAG_Z], 1'b1, 1'b1, cin};
            end
            sm83af_pkg::OP_SCF:
            begin
                res.flags_out = {f[sm83af_pkg::FLAG_Z], 2'b00, 1'b1};
            end
            sm83af_pkg::OP_CCF:
            begin
                res.flags_out = {f[sm83af_pkg::FLAG_Z], 2'b00, ~cin};
            end
            sm83af_pkg::OP_ADD16:
            begin
                res.result    = add17[15:0];
                res.flags_out = {f[sm83af_pkg::FLAG_Z], 1'b0, addh13[12], add17[16]};
            end
            sm83af_pkg::OP_ADDSP:
            begin
                res.result    = sp_sum;
                res.flags_out = {2'b00, sp_h5[4], sp_c9[8]};
            end
            sm83af_pkg::OP_INC16:
            begin
                res.result = item.left + 16'd1;
            end
            sm83af_pkg::OP_DEC16:
            begin
                res.result = item.left - 16'd1;
            end
            default:
            begin
                res.result    = 16'h0000;
                res.flags_out = f;
            end
        endcase
    end

endmodule

>>> rtl/sm83_alu_flags_core.sv
// ALU of an 8-bit SM83-style processor with its flag logic. Each item carries an
// operation code, two operands, a bit index and the incoming Z N H C flags, and
// yields one result item with the value and the new flags. The core is two
// register stages: an input register feeding the combinational ALU, and a result
// register toward the output channel. An accepted item moves from the input register
// into the result register, and a new item is taken every cycle as long as
// the output side keeps taking results; the input-to-result path (the 16-bit
// adders and the operation select) sets the clock rate. There is no internal
// state beyond the two stages, so no warm-up after reset.
`include "sm83_alu_flags_core_assert.svh"

module sm83_alu_flags_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  kind,
    input  logic [15:0] left,
    input  logic [15:0] right,
    input  logic [2:0]  bit_index,
    input  logic [3:0]  flags_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result,
    output logic [3:0]  flags_out
);

    sm83af_pkg::alu_in_t  s1_item_reg;
    logic                 s1_valid_reg;
    sm83af_pkg::alu_out_t alu_res;
    sm83af_pkg::alu_out_t out_item_reg;
    logic                 out_valid_reg;
    logic                 out_adv;
    logic                 in_fire;

    // stage handshakes
    assign out_adv  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_adv;
    assign in_fire  = in_valid && in_ready;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= '{kind: kind, left: left, right: right,
                             bit_index: bit_index, flags_in: flags_in};
        end
    end

    // alu
    sm83af_alu u_alu
    (
        .item (s1_item_reg),
        .res  (alu_res)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            out_item_reg <= alu_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_item_reg.result;
    assign flags_out = out_item_reg.flags_out;

    // checks
    `SM83AF_ASSERT_NEXT(a_in_lands, in_fire, s1_valid_reg)
    `SM83AF_ASSERT_NEXT(a_stage_moves, s1_valid_reg && out_adv, out_valid_reg)
    `SM83AF_ASSERT_SAME(a_byte_ops_high_zero, s1_valid_reg && (s1_item_reg.kind < sm83af_pkg::OP_ADD16), alu_res.result[15:8] == 8'h00)
    `SM83AF_ASSERT_SAME(a_bit_flags, s1_valid_reg && (s1_item_reg.kind == sm83af_pkg::OP_BIT), alu_res.flags_out[2:1] == 2'b01)

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import sm83af_pkg::*;

    // one outstanding result, with the operation that caused it
    typedef struct {
        alu_out_t   want;
        logic [5:0] op;
    } pending_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [5:0]  kind = 6'd0;
    logic [15:0] left = 16'h0000;
    logic [15:0] right = 16'h0000;
    logic [2:0]  bit_index = 3'd0;
    logic [3:0]  flags_in = 4'h0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] result;
    logic [3:0]  flags_out;

    pending_t alu_expected_q[$];
    int       error_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    sm83_alu_flags_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .left      (left),
        .right     (right),
        .bit_index (bit_index),
        .flags_in  (flags_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .flags_out (flags_out)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #200000;
        $display("CHECKS FAILED");
        $finish;
    end

    // alu prediction, flags packed as {z, n, h, c}
    function automatic alu_out_t predict_alu(input logic [5:0] op, input logic [15:0] l,
                                             input logic [15:0] r, input logic [2:0] bi,
                                             input logic [3:0] f);
        alu_out_t    o;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  v;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [16:0] s17;
        logic [12:0] s13;
        logic        cin;
        logic        t;
        logic        wide;
        a = l[7:0];
        b = r[7:0];
        cin = f[FLAG_C];
        v = 8'h00;
        wide = 1'b0;
        o.result = 16'h0000;
        o.flags_out = f;
        case (op)
            OP_ADD, OP_ADC:
            begin
                t = (op == OP_ADC) ? cin : 1'b0;
                s9 = {1'b0, a} + {1'b0, b} + {8'h00, t};
                s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
                v = s9[7:0];
                o.flags_out = {v == 8'h00, 1'b0, s5[4], s9[8]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                t = (op == OP_SBC) ? cin : 1'b0;
                s9 = {1'b0, a} - {1'b0, b} - {8'h00, t};
                s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
                // compare keeps the left operand
                v = (op == OP_CP) ? a : s9[7:0];
                o.flags_out = {s9[7:0] == 8'h00, 1'b1, s5[4], s9[8]};
            end
            OP_AND:
            begin
                v = a & b;
                o.flags_out = {v == 8'h00, 3'b010};
            end
            OP_XOR:
            begin
                v = a ^ b;
                o.flags_out = {v == 8'h00, 3'b000};
            end
            OP_OR:
            begin
                v = a | b;
                o.flags_out = {v == 8'h00, 3'b000};
            end
            // accumulator rotates always clear z
            OP_RLC, OP_RLCA:
            begin
                v = {a[6:0], a[7]};
                o.flags_out = {(op == OP_RLC) && v == 8'h00, 2'b00, a[7]};
            end
            OP_RRC, OP_RRCA:
            begin
                v = {a[0], a[7:1]};
                o.flags_out = {(op == OP_RRC) && v == 8'h00, 2'b00, a[0]};
            end
            OP_RL, OP_RLA:
            begin
                v = {a[6:0], cin};
                o.flags_out = {(op == OP_RL) && v == 8'h00, 2'b00, a[7]};
            end
            OP_RR, OP_RRA:
            begin
                v = {cin, a[7:1]};
                o.flags_out = {(op == OP_RR) && v == 8'h00, 2'b00, a[0]};
            end
            OP_SLA:
            begin
                v = {a[6:0], 1'b0};
                o.flags_out = {v == 8'h00, 2'b00, a[7]};
            end
            OP_SRA:
            begin
                v = {a[7], a[7:1]};
                o.flags_out = {v == 8'h00, 2'b00, a[0]};
            end
            OP_SWAP:
            begin
                v = {a[3:0], a[7:4]};
                o.flags_out = {v == 8'h00, 3'b000};
            end
            OP_SRL:
            begin
                v = {1'b0, a[7:1]};
                o.flags_out = {v == 8'h00, 2'b00, a[0]};
            end
            OP_BIT:
            begin
                v = a;
                o.flags_out = {~a[bi], 1'b0, 1'b1, cin};
            end
            OP_RES:
                v = a & ~(8'h01 << bi);
            OP_SET:
                v = a | (8'h01 << bi);
            OP_INC8:
            begin
                v = a + 8'h01;
                o.flags_out = {v == 8'h00, 1'b0, v[3:0] == 4'h0, cin};
            end
            OP_DEC8:
            begin
                v = a - 8'h01;
                o.flags_out = {v == 8'h00, 1'b1, v[3:0] == 4'hf, cin};
            end
            // decimal adjust: after a subtraction only h and c pick the correction
            OP_DAA:
            begin
                v = a;
                t = cin;
                if (f[FLAG_N])
                begin
                    if (f[FLAG_H])
                        v = v - 8'h06;
                    if (cin)
                        v = v - 8'h60;
                end
                else
                begin
                    if (cin || a > 8'h99)
                    begin
                        v = v + 8'h60;
                        t = 1'b1;
                    end
                    if (f[FLAG_H] || v[3:0] > 4'h9)
                        v = v + 8'h06;
                end
                o.flags_out = {v == 8'h00, f[FLAG_N], 1'b0, t};
            end
            OP_CPL:
            begin
                v = ~a;
                o.flags_out = {f[FLAG_Z], 1'b1, 1'b1, f[FLAG_C]};
            end
            OP_SCF:
                o.flags_out = {f[FLAG_Z], 3'b001};
            OP_CCF:
                o.flags_out = {f[FLAG_Z], 2'b00, ~cin};
            OP_ADD16:
            begin
                wide = 1'b1;
                s17 = {1'b0, l} + {1'b0, r};
                s13 = {1'b0, l[11:0]} + {1'b0, r[11:0]};
                o.result = s17[15:0];
                o.flags_out = {f[FLAG_Z], 1'b0, s13[12], s17[16]};
            end
            // sp plus sign-extended offset, carries from the low byte
            OP_ADDSP:
            begin
                wide = 1'b1;
                o.result = l + {{8{b[7]}}, b};
                s5 = {1'b0, l[3:0]} + {1'b0, b[3:0]};
                s9 = {1'b0, l[7:0]} + {1'b0, b};
                o.flags_out = {2'b00, s5[4], s9[8]};
            end
            OP_INC16:
            begin
                wide = 1'b1;
                o.result = l + 16'h0001;
            end
            OP_DEC16:
            begin
                wide = 1'b1;
                o.result = l - 16'h0001;
            end
            default:
                o.flags_out = f;
        endcase
        if (!wide)
            o.result = {8'h00, v};
        return o;
    endfunction

    // operand mix with extremes
    function automatic logic [15:0] random_operand();
        logic [15:0] w;
        case ($urandom_range(0, 11))
            0: w = 16'h0000;
            1: w = 16'hffff;
            2: w = 16'h00ff;
            3: w = 16'h0080;
            4: w = 16'h0fff;
            5: w = 16'h007f;
            default: w = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [5:0] op,
                                   input logic [15:0] got, input logic [15:0] want);
        $display("mismatch: %s, kind %0d, got %h, expected %h", what, op, got, want);
        error_count++;
    endtask

    // send one item, record its expected result on acceptance
    task automatic send_alu_item(input logic [5:0] op, input logic [15:0] l,
                                 input logic [15:0] r, input logic [2:0] bi,
                                 input logic [3:0] f);
        pending_t p;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        kind <= op;
        left <= l;
        right <= r;
        bit_index <= bi;
        flags_in <= f;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        p.want = predict_alu(op, l, r, bi, f);
        p.op = op;
        alu_expected_q.push_back(p);
    endtask

    // hold off the sender until every pending result is back
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (alu_expected_q.size() != 0);
    endtask

    // one item per operation code with rotating extreme operands
    task automatic test_every_op();
        logic [15:0] lv[6];
        int i;
        lv = '{16'h0000, 16'hffff, 16'h0080, 16'h7fff, 16'h00ff, 16'h0f0f};
        for (i = 0; i <= OP_DEC16; i++)
            send_alu_item(6'(i), lv[3'(i % 6)], lv[3'((i + 3) % 6)], 3'(i), 4'(i));
    endtask

    // decimal adjust after add and after subtract
    task automatic test_decimal_adjust();
        send_alu_item(OP_DAA, 16'h009a, 16'h0000, 3'd0, 4'b0000);
        send_alu_item(OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'b0111);
        send_alu_item(OP_DAA, 16'h0045, 16'h0000, 3'd0, 4'b0110);
        send_alu_item(OP_DAA, 16'h0099, 16'h0000, 3'd0, 4'b0001);
    endtask

    // codes past the last operation give zero and keep the flags
    task automatic test_unused_codes();
        send_alu_item(6'd33, 16'hffff, 16'hffff, 3'd7, 4'hf);
        send_alu_item(6'd63, 16'h1234, 16'h8765, 3'd3, 4'h5);
    endtask

    // random items under one idling profile
    task automatic test_random_phase(input int count, input int idle, input int stall);
        logic [5:0] op;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                op = 6'($urandom_range(33, 63));
            else
                op = 6'($urandom_range(0, OP_DEC16));
            send_alu_item(op, random_operand(), random_operand(),
                          3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        end
        wait_until_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // compare each result with the oldest pending item
    always @(posedge clk)
    begin : check_results
        pending_t head;
        if (rst_n && out_valid && out_ready)
        begin
            if (alu_expected_q.size() == 0)
                report_mismatch("result with no item pending", 6'd0, result, 16'h0000);
            else
            begin
                head = alu_expected_q.pop_front();
                if (result !== head.want.result)
                    report_mismatch("result", head.op, result, head.want.result);
                if (flags_out !== head.want.flags_out)
                    report_mismatch("flags_out", head.op, {12'h000, flags_out},
                                    {12'h000, head.want.flags_out});
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_every_op();
        test_decimal_adjust();
        test_unused_codes();
        wait_until_drained();
        test_random_phase(165, 0, 0);
        test_random_phase(160, 72, 0);
        test_random_phase(160, 0, 72);
        test_random_phase(165, 26, 26);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
